[hw/rtl/bms_pkg.sv]
// Brace match scanner: shared types, character codes and widths.
// No dependencies; every other file in this block refers to it by scoped name.
package bms_pkg;

  // Width of the saturating brace depth and of the byte counter
  localparam int DEPTH_BITS = 16;
  localparam int COUNT_BITS = 32;
  localparam int LEN_BITS   = 32;

  // ASCII codes the scanner reacts to
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Saturation bounds of the signed depth
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  // Lexical mode of the scanner
  typedef enum logic [5:0] {
    MODE_CODE  = 6'b000001,
    MODE_SLASH = 6'b000010,
    MODE_LINE  = 6'b000100,
    MODE_BLOCK = 6'b001000,
    MODE_STR   = 6'b010000,
    MODE_CHR   = 6'b100000
  } scan_mode_t;

  // One input beat
  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_byte;
    logic       last_byte;
  } text_beat_t;

  // One result beat
  typedef struct packed {
    logic                found;
    logic [LEN_BITS-1:0] match_length;
  } result_beat_t;

  // Clamp the byte count into the result length field
  function automatic logic [LEN_BITS-1:0] sat_len(input logic [COUNT_BITS-1:0] count);
    logic [63:0] wide;
    wide = 64'(count);
    if (wide > 64'(32'hFFFF_FFFF)) begin
      return '1;
    end
    return wide[LEN_BITS-1:0];
  endfunction

endpackage

[hw/rtl/brace_match_scanner.sv]
// Brace match scanner top level: input skid register, scan logic, result register.
// Depends on bms_pkg, bms_skid, bms_scan and bms_result.
//
// Streams source text one byte per beat. A beat with first_byte set starts a
// search (normally at an opening brace); the block tracks brace depth while
// skipping line comments, block comments, string and character literals, and
// delivers one result beat when the brace that brings depth back to zero is
// seen (found = 1, match_length = bytes through that brace) or when the beat
// with last_byte set arrives first (found = 0, match_length = 0). Bytes that
// arrive with no search running are dropped without a result; first_byte in
// the middle of a search restarts it. One byte is taken every cycle unless a
// result waits on result_stall; the per-byte mode, depth and count update is
// a single registered step between the holding and result registers. text_stall
// is a register output and only rises when a result waits on result_stall.
module brace_match_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        found,
  output logic [31:0] match_length
);

  bms_pkg::text_beat_t   in_beat;
  bms_pkg::text_beat_t   hold_beat;
  bms_pkg::result_beat_t scan_beat;
  bms_pkg::result_beat_t out_beat;
  logic                  hold_valid;
  logic                  advance;
  logic                  has_result;
  logic                  out_ready;

  assign in_beat.text_byte  = text_byte;
  assign in_beat.first_byte = first_byte;
  assign in_beat.last_byte  = last_byte;

  // A held byte moves on unless its result has nowhere to go
  assign advance = hold_valid && (!has_result || out_ready);

  bms_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_beat  (in_beat),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_beat  (hold_beat)
  );

  bms_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .beat       (hold_beat),
    .has_result (has_result),
    .result     (scan_beat)
  );

  bms_result u_result (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && has_result),
    .load_beat    (scan_beat),
    .ready        (out_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (out_beat)
  );

  assign found        = out_beat.found;
  assign match_length = out_beat.match_length;

endmodule

[hw/rtl/bms_skid.sv]
// Brace match scanner: input register with a one-entry skid buffer.
// Depends on bms_pkg for the beat type; stall back to the source is registered.
module bms_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_stall,
  input  bms_pkg::text_beat_t text_beat,
  input  logic                advance,
  output logic                hold_valid,
  output bms_pkg::text_beat_t hold_beat
);

  logic                skid_valid;
  bms_pkg::text_beat_t skid_beat;
  logic                take;

  assign text_stall = skid_valid;
  assign take       = text_valid && !skid_valid;

  // Control: holding register refills from skid first, then from the port
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!hold_valid || advance) begin
      hold_valid <= skid_valid || take;
      skid_valid <= 1'b0;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!hold_valid || advance) begin
      if (skid_valid) begin
        hold_beat <= skid_beat;
      end else if (take) begin
        hold_beat <= text_beat;
      end
    end else if (take) begin
      skid_beat <= text_beat;
    end
  end

endmodule

[hw/rtl/bms_scan.sv]
// Brace match scanner: lexical mode, depth and count state with the per-byte update.
// Depends on bms_pkg for modes, character codes and beat types.
module bms_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  bms_pkg::text_beat_t   beat,
  output logic                  has_result,
  output bms_pkg::result_beat_t result
);

  bms_pkg::scan_mode_t                      scan_mode, scan_mode_next;
  logic [7:0]                               previous_byte;
  logic signed [bms_pkg::DEPTH_BITS-1:0]    brace_depth, brace_depth_next;
  logic [bms_pkg::COUNT_BITS-1:0]           byte_count, byte_count_next;
  logic                                     search_done;

  bms_pkg::scan_mode_t                      mode_base;
  logic [7:0]                               prev_base;
  logic signed [bms_pkg::DEPTH_BITS-1:0]    depth_base;
  logic [bms_pkg::COUNT_BITS-1:0]           count_base;
  logic                                     active;
  logic                                     code_path;
  logic                                     hit;
  logic [7:0]                               c;

  assign c = beat.text_byte;

  // Per-byte update
  always_comb begin
    if (beat.first_byte) begin
      mode_base  = bms_pkg::MODE_CODE;
      prev_base  = 8'h00;
      depth_base = '0;
      count_base = '0;
      active     = 1'b1;
    end else begin
      mode_base  = scan_mode;
      prev_base  = previous_byte;
      depth_base = brace_depth;
      count_base = byte_count;
      active     = !search_done;
    end

    byte_count_next  = (count_base != '1) ? count_base + 1'b1 : count_base;
    scan_mode_next   = mode_base;
    brace_depth_next = depth_base;
    code_path        = 1'b0;
    hit              = 1'b0;

    // Comment and literal modes just look for their terminator
    case (mode_base)
      bms_pkg::MODE_LINE: begin
        if (c == bms_pkg::CH_NEWLINE) scan_mode_next = bms_pkg::MODE_CODE;
      end
      bms_pkg::MODE_BLOCK: begin
        if (c == bms_pkg::CH_SLASH && prev_base == bms_pkg::CH_STAR) begin
          scan_mode_next = bms_pkg::MODE_CODE;
        end
      end
      bms_pkg::MODE_STR: begin
        if (c == bms_pkg::CH_DQUOTE && prev_base != bms_pkg::CH_BSLASH) begin
          scan_mode_next = bms_pkg::MODE_CODE;
        end
      end
      bms_pkg::MODE_CHR: begin
        if (c == bms_pkg::CH_SQUOTE && prev_base != bms_pkg::CH_BSLASH) begin
          scan_mode_next = bms_pkg::MODE_CODE;
        end
      end
      bms_pkg::MODE_SLASH: begin
        if (c == bms_pkg::CH_SLASH) begin
          scan_mode_next = bms_pkg::MODE_LINE;
        end else if (c == bms_pkg::CH_STAR) begin
          scan_mode_next = bms_pkg::MODE_BLOCK;
        end else begin
          code_path = 1'b1;
        end
      end
      default: begin
        code_path = 1'b1;
      end
    endcase

    // Plain code: openers and braces
    if (code_path) begin
      scan_mode_next = bms_pkg::MODE_CODE;
      if (c == bms_pkg::CH_SLASH) begin
        // a slash on the final byte cannot open a comment
        if (!beat.last_byte) scan_mode_next = bms_pkg::MODE_SLASH;
      end else if (c == bms_pkg::CH_DQUOTE) begin
        scan_mode_next = bms_pkg::MODE_STR;
      end else if (c == bms_pkg::CH_SQUOTE) begin
        scan_mode_next = bms_pkg::MODE_CHR;
      end else if (c == bms_pkg::CH_LBRACE) begin
        if (depth_base != bms_pkg::DEPTH_MAX) brace_depth_next = depth_base + 1'b1;
      end else if (c == bms_pkg::CH_RBRACE) begin
        if (depth_base != bms_pkg::DEPTH_MIN) brace_depth_next = depth_base - 1'b1;
        hit = (brace_depth_next == '0);
      end
    end
  end

  // Result: match wins over end of text
  assign has_result          = active && (hit || beat.last_byte);
  assign result.found        = hit;
  assign result.match_length = hit ? bms_pkg::sat_len(byte_count_next) : '0;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= bms_pkg::MODE_CODE;
      previous_byte <= 8'h00;
      brace_depth   <= '0;
      byte_count    <= '0;
      search_done   <= 1'b1;
    end else if (step && active) begin
      scan_mode     <= scan_mode_next;
      previous_byte <= c;
      brace_depth   <= brace_depth_next;
      byte_count    <= byte_count_next;
      search_done   <= hit || beat.last_byte;
    end
  end

endmodule

[hw/rtl/bms_result.sv]
// Brace match scanner: output register holding one result beat.
// Depends on bms_pkg for the result type.
module bms_result (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  bms_pkg::result_beat_t load_beat,
  output logic                  ready,
  output logic                  result_valid,
  input  logic                  result_stall,
  output bms_pkg::result_beat_t result_beat
);

  // Free when empty or when the held beat leaves this cycle
  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      result_beat <= load_beat;
    end
  end

endmodule

[dv/brace_match_scanner_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for brace_match_scanner: directed table, a long result hold-off, then random text.
// Depends on bms_pkg and brace_match_scanner; expects every result beat from an in-bench prediction or the table.
module brace_match_scanner_test;

  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_BEATS = 480;

  typedef enum logic [1:0] {
    WANT_MODEL,
    WANT_NONE,
    WANT_FOUND,
    WANT_MISS
  } want_t;

  typedef struct packed {
    logic                         found;
    logic [bms_pkg::LEN_BITS-1:0] span;
  } match_t;

  typedef struct {
    logic [7:0]  ch;
    logic        first;
    logic        last;
    want_t       want;
    int unsigned want_len;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_stall;
  logic [7:0]  text_byte = 8'h00;
  logic        first_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        found;
  logic [31:0] match_length;

  // Predicted scanner state
  bms_pkg::scan_mode_t                    lex_mode;
  logic [7:0]                             prior_byte;
  logic signed [bms_pkg::DEPTH_BITS-1:0]  nest_depth;
  logic [bms_pkg::COUNT_BITS-1:0]         bytes_seen;
  logic                                   scan_idle;

  match_t      pending_matches[$];
  script_row_t script[$];
  int          scanned_beats = 0;
  int          fault_count = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  logic        hold_req = 1'b0;
  logic        steady = 1'b0;

  brace_match_scanner u_top (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .first_byte   (first_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found),
    .match_length (match_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Plain-code handling of one byte: literal/comment openers and depth
  task automatic code_token(input logic [7:0] ch, inout logic hit);
    if (ch == bms_pkg::CH_SLASH) begin
      lex_mode = bms_pkg::MODE_SLASH;
    end else if (ch == bms_pkg::CH_DQUOTE) begin
      lex_mode = bms_pkg::MODE_STR;
    end else if (ch == bms_pkg::CH_SQUOTE) begin
      lex_mode = bms_pkg::MODE_CHR;
    end else if (ch == bms_pkg::CH_LBRACE) begin
      if (nest_depth != bms_pkg::DEPTH_MAX) nest_depth = nest_depth + 1'b1;
    end else if (ch == bms_pkg::CH_RBRACE) begin
      if (nest_depth != bms_pkg::DEPTH_MIN) nest_depth = nest_depth - 1'b1;
      if (nest_depth == '0) hit = 1'b1;
    end
    prior_byte = ch;
  endtask

  // Advance the predicted scanner by one accepted beat
  task automatic predict_match(input logic [7:0] ch, input logic f, input logic l,
                               output logic has_res, output match_t res);
    logic hit;
    hit = 1'b0;
    has_res = 1'b0;
    res = '0;
    if (f) begin
      lex_mode = bms_pkg::MODE_CODE;
      prior_byte = 8'h00;
      nest_depth = '0;
      bytes_seen = '0;
      scan_idle = 1'b0;
    end else if (scan_idle) begin
      return;
    end
    if (bytes_seen != '1) bytes_seen = bytes_seen + 1'b1;
    case (lex_mode)
      bms_pkg::MODE_LINE: begin
        if (ch == bms_pkg::CH_NEWLINE) lex_mode = bms_pkg::MODE_CODE;
        prior_byte = ch;
      end
      bms_pkg::MODE_BLOCK: begin
        // a slash right after any star closes, including the opening star
        if (ch == bms_pkg::CH_SLASH && prior_byte == bms_pkg::CH_STAR) begin
          lex_mode = bms_pkg::MODE_CODE;
        end
        prior_byte = ch;
      end
      bms_pkg::MODE_STR: begin
        if (ch == bms_pkg::CH_DQUOTE && prior_byte != bms_pkg::CH_BSLASH) begin
          lex_mode = bms_pkg::MODE_CODE;
        end
        prior_byte = ch;
      end
      bms_pkg::MODE_CHR: begin
        if (ch == bms_pkg::CH_SQUOTE && prior_byte != bms_pkg::CH_BSLASH) begin
          lex_mode = bms_pkg::MODE_CODE;
        end
        prior_byte = ch;
      end
      bms_pkg::MODE_SLASH: begin
        if (ch == bms_pkg::CH_SLASH) begin
          lex_mode = bms_pkg::MODE_LINE;
          prior_byte = ch;
        end else if (ch == bms_pkg::CH_STAR) begin
          lex_mode = bms_pkg::MODE_BLOCK;
          prior_byte = ch;
        end else begin
          // lone slash was plain code; this byte is code too
          lex_mode = bms_pkg::MODE_CODE;
          code_token(ch, hit);
        end
      end
      default: begin
        lex_mode = bms_pkg::MODE_CODE;
        code_token(ch, hit);
        // a trailing slash opens nothing
        if (l && lex_mode == bms_pkg::MODE_SLASH) lex_mode = bms_pkg::MODE_CODE;
      end
    endcase
    if (hit) begin
      has_res = 1'b1;
      res.found = 1'b1;
      res.span = bytes_seen;
      scan_idle = 1'b1;
    end else if (l) begin
      has_res = 1'b1;
      scan_idle = 1'b1;
    end
  endtask

  // Present one beat and hold it until accepted, with random gaps ahead of it
  task automatic send_beat(input logic [7:0] ch, input logic f, input logic l);
    if (!steady && $urandom_range(99) < 15) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte <= ch;
    first_byte <= f;
    last_byte <= l;
    @(posedge clk);
    while (text_stall) @(posedge clk);
  endtask

  // Send a beat, predict it and queue what it should produce
  task automatic feed(input logic [7:0] ch, input logic f, input logic l,
                      input want_t want, input int unsigned want_len);
    logic   has_res;
    match_t res;
    match_t typed;
    send_beat(ch, f, l);
    if (f || !scan_idle) scanned_beats++;
    predict_match(ch, f, l, has_res, res);
    typed.found = (want == WANT_FOUND);
    typed.span = (want == WANT_FOUND) ? want_len : '0;
    case (want)
      WANT_MODEL: if (has_res) pending_matches = {pending_matches, res};
      WANT_FOUND, WANT_MISS: pending_matches = {pending_matches, typed};
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [7:0] ch, input logic f, input logic l,
                         input want_t want, input int unsigned want_len);
    script_row_t r;
    r.ch = ch;
    r.first = f;
    r.last = l;
    r.want = want;
    r.want_len = want_len;
    script = {script, r};
  endtask

  // Byte mix rich in the characters the scanner reacts to
  function automatic logic [7:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 20) return bms_pkg::CH_LBRACE;
    if (roll < 38) return bms_pkg::CH_RBRACE;
    if (roll < 48) return bms_pkg::CH_SLASH;
    if (roll < 56) return bms_pkg::CH_STAR;
    if (roll < 63) return bms_pkg::CH_DQUOTE;
    if (roll < 69) return bms_pkg::CH_SQUOTE;
    if (roll < 74) return bms_pkg::CH_BSLASH;
    if (roll < 79) return bms_pkg::CH_NEWLINE;
    return 8'($urandom_range(255));
  endfunction

  // Result beat checker
  always @(posedge clk) begin
    match_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_matches.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result beat: expected none, actual found=%0b match_length=%0d",
                 $time, found, match_length);
      end else begin
        want = pending_matches.pop_front();
        if (found !== want.found) begin
          fault_count++;
          $display("%0t: found mismatch: expected %0b actual %0b", $time, want.found, found);
        end
        if (match_length !== want.span) begin
          fault_count++;
          $display("%0t: match_length mismatch: expected %0d actual %0d",
                   $time, want.span, match_length);
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      result_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_req <= 1'b0;
    end else begin
      result_stall <= !steady && ($urandom_range(99) < 15);
    end
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((text_valid && !text_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("brace_match_scanner verification failed");
      $finish;
    end
  end

  initial begin
    int          i;
    int          len;
    int          target;
    logic        f;
    logic        l;
    logic [7:0]  ch;
    script_row_t r;

    lex_mode = bms_pkg::MODE_CODE;
    prior_byte = 8'h00;
    nest_depth = '0;
    bytes_seen = '0;
    scan_idle = 1'b1;

    // Directed table
    add_row("x", 1'b0, 1'b0, WANT_NONE, 0);          // no search running: dropped
    add_row(bms_pkg::CH_LBRACE, 1'b1, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_LBRACE, 1'b1, 1'b0, WANT_MODEL, 0);   // restart mid-search
    add_row(bms_pkg::CH_RBRACE, 1'b0, 1'b0, WANT_FOUND, 2);
    // line comment, /*/ quirk, escaped quote, char literal, lone slash, match on last
    add_row(bms_pkg::CH_LBRACE, 1'b1, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_SLASH, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_SLASH, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_RBRACE, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_NEWLINE, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_SLASH, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_STAR, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_SLASH, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_DQUOTE, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_BSLASH, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_DQUOTE, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_RBRACE, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_DQUOTE, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_SQUOTE, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_RBRACE, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_SQUOTE, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_SLASH, 1'b0, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_RBRACE, 1'b0, 1'b1, WANT_FOUND, 18);
    // slash on the last byte opens nothing
    add_row(bms_pkg::CH_LBRACE, 1'b1, 1'b0, WANT_MODEL, 0);
    add_row(bms_pkg::CH_SLASH, 1'b0, 1'b1, WANT_MISS, 0);
    // closing brace to depth -1 on a one-byte text
    add_row(bms_pkg::CH_RBRACE, 1'b1, 1'b1, WANT_MISS, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[k]) begin
      r = script[k];
      feed(r.ch, r.first, r.last, r.want, r.want_len);
    end

    // Long receiver hold-off while tight searches keep coming
    hold_req <= 1'b1;
    for (i = 0; i < 20; i++) begin
      feed(bms_pkg::CH_LBRACE, 1'b1, 1'b0, WANT_MODEL, 0);
      feed(bms_pkg::CH_RBRACE, 1'b0, 1'b0, WANT_MODEL, 0);
    end

    // Random text: mostly searches, some noise
    target = scanned_beats + RANDOM_BEATS;
    steady = 1'b1;
    while (scanned_beats < target) begin
      if (steady && scanned_beats > target - RANDOM_BEATS + 120) steady = 1'b0;
      if ($urandom_range(99) < 80) begin
        ch = ($urandom_range(9) == 0) ? pick_char() : bms_pkg::CH_LBRACE;
        feed(ch, 1'b1, 1'b0, WANT_MODEL, 0);
        len = $urandom_range(40, 1);
        for (i = 0; i < len && !scan_idle; i++) begin
          l = (i == len - 1) ? ($urandom_range(1) == 1) : ($urandom_range(49) == 0);
          feed(pick_char(), 1'b0, l, WANT_MODEL, 0);
        end
      end else begin
        len = $urandom_range(8, 1);
        for (i = 0; i < len; i++) begin
          f = ($urandom_range(9) == 0);
          l = ($urandom_range(9) == 0);
          feed(8'($urandom_range(255)), f, l, WANT_MODEL, 0);
        end
      end
    end

    text_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fault_count == 0) begin
      $display("brace_match_scanner verification clean");
    end else begin
      $display("brace_match_scanner verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bms_pkg.sv
hw/rtl/bms_skid.sv
hw/rtl/bms_scan.sv
hw/rtl/bms_result.sv
hw/rtl/brace_match_scanner.sv
dv/brace_match_scanner_test.sv
